### rtl/sit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert table package
// Shared constants, result status codes and the command and status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sit_pkg;

    // Default table depth and stored value width.
    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Widths of the fixed result and request fields.
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int STATUS_W = 2;

    // Request types.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFILL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request word and start position
        logic rd_idx;   // read the entry at the requested index
        logic rd_k;     // read the entry just below the open slot
        logic shift;    // move the entry read into the open slot
        logic place;    // write the new value into the open slot
        logic finish;   // load the result registers and update the count
    } sit_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;  // the current request is a read
        logic full;     // the table holds CAPACITY entries
        logic k_zero;   // the open slot is at the bottom of the table
        logic ge;       // the entry read is not smaller than the new value
    } sit_stat_t;

endpackage

### rtl/sit_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert table controller
// Sequences each request word through the datapath: an indexed read, or one
// read per compared entry, a placement unless full, and the result hand-off.
// ----------------------------------------------------------------------------
module sit_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  sit_pkg::sit_stat_t stat,
    output sit_pkg::sit_cmd_t  cmd
);
    import sit_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_finish;

    // The result register is free when empty or being emptied this cycle.
    assign can_finish = !out_valid_reg || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                priority if (stat.is_read)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_FIN;
                end
                else if (stat.full)
                begin
                    state_next = S_FIN;
                end
                else if (stat.k_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_k   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.ge)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (can_finish)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/sit_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert table datapath
// Holds the entry memory, the fill count, the open-slot pointer and the
// result registers, and reports compare results to the controller.
// ----------------------------------------------------------------------------
module sit_dp #(
    parameter int CAPACITY    = sit_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sit_pkg::sit_cmd_t                   cmd,
    output sit_pkg::sit_stat_t                  stat,
    input  logic                                req_type,
    input  logic signed [31:0]                  value,
    input  logic [sit_pkg::INDEX_W-1:0]         index,
    output logic [sit_pkg::STATUS_W-1:0]        status,
    output logic signed [31:0]                  read_value,
    output logic [sit_pkg::INDEX_W-1:0]         position,
    output logic [sit_pkg::COUNT_W-1:0]         entry_count
);
    import sit_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int XW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int YW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Entry memory, one write and one registered read per cycle.
    logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;

    logic                          is_read_reg;
    logic signed [VALUE_WIDTH-1:0] v_reg;
    logic [INDEX_W-1:0]            idx_reg;
    logic [CNT_W-1:0]              k_reg;
    logic [CNT_W-1:0]              k_next;
    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;

    logic [STATUS_W-1:0]           status_reg;
    logic signed [31:0]            read_value_reg;
    logic [INDEX_W-1:0]            position_reg;
    logic [COUNT_W-1:0]            entry_count_reg;

    logic                          full;
    logic [XW-1:0]                 idx_x;
    logic [XW-1:0]                 fill_x;
    logic [XW-1:0]                 k_x;
    logic [YW-1:0]                 cnt_y;
    logic                          idx_hit;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic signed [VALUE_WIDTH-1:0] wdata;
    logic                          re;
    logic [AW-1:0]                 raddr;

    assign full   = (fill_reg == CNT_W'(CAPACITY));
    assign idx_x  = XW'(idx_reg);
    assign fill_x = XW'(fill_reg);
    assign k_x    = XW'(k_reg);
    assign idx_hit = (idx_x < fill_x) && (idx_x < XW'(CAPACITY));

    // Status toward the controller.
    assign stat.is_read = is_read_reg;
    assign stat.full    = full;
    assign stat.k_zero  = (k_reg == '0);
    assign stat.ge      = (rdata_reg >= v_reg);

    // Memory port selection.
    assign we    = cmd.shift || cmd.place;
    assign waddr = k_reg[AW-1:0];
    assign wdata = cmd.shift ? rdata_reg : v_reg;
    assign re    = cmd.rd_idx || cmd.rd_k;
    assign raddr = cmd.rd_idx ? idx_x[AW-1:0] : AW'(k_reg - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_read_reg <= (req_type == REQ_READ);
            v_reg       <= VALUE_WIDTH'(value);
            idx_reg     <= index;
        end
    end

    // Open-slot pointer starts at the fill count and walks down.
    always_comb
    begin
        k_next = k_reg;
        priority if (cmd.load)
        begin
            k_next = fill_reg;
        end
        else if (cmd.shift)
        begin
            k_next = k_reg - CNT_W'(1);
        end
    end

    // Fill count grows by one for each accepted insert.
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.finish && !is_read_reg && !full)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    assign cnt_y = YW'(fill_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            k_reg    <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            k_reg    <= k_next;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            entry_count_reg <= cnt_y[COUNT_W-1:0];
            if (is_read_reg)
            begin
                position_reg <= '0;
                if (idx_hit)
                begin
                    status_reg     <= ST_OK;
                    read_value_reg <= 32'(rdata_reg);
                end
                else
                begin
                    status_reg     <= ST_NOFILL;
                    read_value_reg <= '0;
                end
            end
            else
            begin
                read_value_reg <= '0;
                if (full)
                begin
                    status_reg   <= ST_FULL;
                    position_reg <= '0;
                end
                else
                begin
                    status_reg   <= ST_OK;
                    position_reg <= k_x[INDEX_W-1:0];
                end
            end
        end
    end

    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

endmodule

### rtl/sorted_insert_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert table
// A read or a rejected insert loads its result without moving entries; an insert
// moves up each entry not below the value, one memory read and one write per
// move, then writes the value into the open slot.
// The next word is accepted the cycle after the result register is loaded.
// Reset clears the fill count and control; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_table #(
    parameter int CAPACITY    = sit_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic signed [31:0]            value,
    input  logic [sit_pkg::INDEX_W-1:0]   index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sit_pkg::STATUS_W-1:0]  status,
    output logic signed [31:0]            read_value,
    output logic [sit_pkg::INDEX_W-1:0]   position,
    output logic [sit_pkg::COUNT_W-1:0]   entry_count
);
    import sit_pkg::*;

    sit_cmd_t  cmd;
    sit_stat_t stat;

    // Sequencer.
    sit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Entry storage and result datapath.
    sit_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .value       (value),
        .index       (index),
        .status      (status),
        .read_value  (read_value),
        .position    (position),
        .entry_count (entry_count)
    );

endmodule
